// ===== hw/rtl/form_field_value_extractor_unit_assert.svh =====
// assertion macros used by the form value extractor front part
`ifndef FORM_FIELD_VALUE_EXTRACTOR_UNIT_ASSERT_SVH
`define FORM_FIELD_VALUE_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FVX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FVX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fvx_pkg.sv =====
// shared types, constants and decode helpers of the form value extractor
package fvx_pkg;

    // default sizes
    localparam int KEY_MAX_CHARS_DEF   = 8;
    localparam int VALUE_MAX_BYTES_DEF = 128;
    localparam int QUEUE_DEPTH         = 4;
    localparam int RESULTS_MAX         = 4;

    // configuration register indexes
    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_KEY_CHARS      = 2'd0;
    localparam reg_index_t REG_KEY_LENGTH     = 2'd1;
    localparam reg_index_t REG_VALUE_CAPACITY = 2'd2;

    // configuration reset values
    localparam logic [63:0] KEY_CHARS_RST      = 64'd0;
    localparam logic [3:0]  KEY_LENGTH_RST     = 4'd4;
    localparam logic [7:0]  VALUE_CAPACITY_RST = 8'd33;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_PENDING   = 2'd0;
    localparam status_t ST_FOUND     = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_TOO_LONG  = 2'd3;

    // special characters
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [63:0] key_chars;
        logic [3:0]  key_length;
        logic [7:0]  value_capacity;
    } cfg_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       value_valid;
        status_t    status;
        logic       last;
    } result_t;

    // results caused by one body byte, res[0] first
    typedef struct packed {
        logic [2:0]                    count;
        result_t [RESULTS_MAX-1:0]     res;
    } cmd_t;

    // running list of results while one byte is worked out
    typedef struct packed {
        logic [2:0]                    count;
        logic [7:0]                    used;
        logic                          closed;
        result_t [RESULTS_MAX-1:0]     res;
    } emit_t;

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        if (b <= 8'h39)
            d = b - 8'h30;
        else if (b >= 8'h61)
            d = b - 8'h57;
        else
            d = b - 8'h37;
        return d[3:0];
    endfunction

    function automatic emit_t emit_put(input emit_t e, input logic [7:0] b,
                                       input logic v, input status_t st, input logic l);
        emit_t r;
        r = e;
        r.res[e.count[1:0]] = '{value_byte: b, value_valid: v, status: st, last: l};
        r.count = e.count + 3'd1;
        return r;
    endfunction

    // one value byte if there is room, else the too-long closing result
    function automatic emit_t emit_push(input emit_t e, input logic [7:0] b,
                                        input logic [7:0] cap);
        emit_t r;
        r = e;
        if (!e.closed) begin
            if (({1'b0, e.used} + 9'd1) >= {1'b0, cap}) begin
                r = emit_put(e, 8'd0, 1'b0, ST_TOO_LONG, 1'b1);
                r.closed = 1'b1;
            end else begin
                r = emit_put(e, b, 1'b1, ST_PENDING, 1'b0);
                r.used = e.used + 8'd1;
            end
        end
        return r;
    endfunction

    function automatic emit_t emit_close(input emit_t e, input status_t st);
        emit_t r;
        r = e;
        if (!e.closed) begin
            r = emit_put(e, 8'd0, 1'b0, st, 1'b1);
            r.closed = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/fvx_front.sv =====
// front part: key match and value decode, one body byte per cycle while accept is high
`include "form_field_value_extractor_unit_assert.svh"

module fvx_front #(
    parameter int KEY_MAX_CHARS   = fvx_pkg::KEY_MAX_CHARS_DEF,
    parameter int VALUE_MAX_BYTES = fvx_pkg::VALUE_MAX_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    body_byte,
    input  logic          body_end,
    input  fvx_pkg::cfg_t cfg,
    output logic          enq,
    output fvx_pkg::cmd_t cmd
);
    import fvx_pkg::*;

    localparam int KPW = $clog2(KEY_MAX_CHARS + 1);
    localparam int UW  = $clog2(VALUE_MAX_BYTES);

    typedef enum logic [2:0] {
        PH_KEY,
        PH_SKIP,
        PH_VALUE,
        PH_PCT1,
        PH_PCT2,
        PH_DONE
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [KPW-1:0] kpos_reg, kpos_next;
    logic [UW-1:0]  used_reg, used_next;
    logic [7:0]     held_reg, held_next;

    logic [7:0] cap_eff;
    logic [3:0] klen_eff;
    logic [3:0] kp4;
    logic [7:0] key_char;
    logic       do_val;
    emit_t      e;

    // clamp configuration and pick the key character under compare
    assign cap_eff  = (cfg.value_capacity > 8'(VALUE_MAX_BYTES)) ?
                      8'(VALUE_MAX_BYTES) : cfg.value_capacity;
    assign klen_eff = (cfg.key_length > 4'(KEY_MAX_CHARS)) ?
                      4'(KEY_MAX_CHARS) : cfg.key_length;
    assign kp4      = 4'(kpos_reg);
    assign key_char = cfg.key_chars[{kp4[2:0], 3'b000} +: 8];

    // next state and the results of this byte
    always_comb
    begin
        e          = '0;
        e.used     = 8'(used_reg);
        phase_next = phase_reg;
        kpos_next  = kpos_reg;
        held_next  = held_reg;
        do_val     = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_KEY:
                begin
                    if (body_byte == CH_AMP)
                        kpos_next = '0;
                    else if (kp4 < klen_eff)
                    begin
                        if (body_byte == key_char)
                            kpos_next = KPW'(kp4 + 4'd1);
                        else
                            phase_next = PH_SKIP;
                    end
                    else if (body_byte == CH_EQ)
                    begin
                        phase_next = PH_VALUE;
                        e.used     = 8'd0;
                    end
                    else
                        phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (body_byte == CH_AMP)
                    begin
                        phase_next = PH_KEY;
                        kpos_next  = '0;
                    end
                end
                PH_VALUE:
                    do_val = 1'b1;
                PH_PCT1:
                begin
                    if (is_hex(body_byte))
                    begin
                        held_next  = body_byte;
                        phase_next = PH_PCT2;
                    end
                    else
                    begin
                        e          = emit_push(e, CH_PCT, cap_eff);
                        phase_next = PH_VALUE;
                        do_val     = 1'b1;
                    end
                end
                PH_PCT2:
                begin
                    if (is_hex(body_byte))
                        e = emit_push(e, {hex_val(held_reg), hex_val(body_byte)}, cap_eff);
                    else
                    begin
                        e      = emit_push(e, CH_PCT, cap_eff);
                        e      = emit_push(e, held_reg, cap_eff);
                        do_val = 1'b1;
                    end
                    phase_next = PH_VALUE;
                end
                PH_DONE:
                    ;
                default:
                    ;
            endcase

            // ordinary value character
            if (do_val && !e.closed)
            begin
                if (body_byte == CH_AMP)
                    e = emit_close(e, ST_FOUND);
                else if (body_byte == CH_PLUS)
                    e = emit_push(e, CH_SPACE, cap_eff);
                else if (body_byte == CH_PCT)
                    phase_next = PH_PCT1;
                else
                    e = emit_push(e, body_byte, cap_eff);
            end

            if (e.closed)
                phase_next = PH_DONE;

            // end of body: flush an open escape, close, back to field start
            if (body_end)
            begin
                unique case (phase_next) inside
                    PH_KEY, PH_SKIP:
                        e = emit_close(e, ST_NOT_FOUND);
                    PH_PCT1:
                    begin
                        e = emit_push(e, CH_PCT, cap_eff);
                        e = emit_close(e, ST_FOUND);
                    end
                    PH_PCT2:
                    begin
                        e = emit_push(e, CH_PCT, cap_eff);
                        e = emit_push(e, held_next, cap_eff);
                        e = emit_close(e, ST_FOUND);
                    end
                    PH_VALUE:
                        e = emit_close(e, ST_FOUND);
                    default:
                        ;
                endcase
                phase_next = PH_KEY;
                kpos_next  = '0;
                e.used     = 8'd0;
                held_next  = 8'd0;
            end
        end
        used_next = UW'(e.used);
    end

    assign enq       = accept && (e.count != 3'd0);
    assign cmd.count = e.count;
    assign cmd.res   = e.res;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            kpos_reg  <= '0;
            used_reg  <= '0;
            held_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            kpos_reg  <= kpos_next;
            used_reg  <= used_next;
            held_reg  <= held_next;
        end
    end

    // checks
    `FVX_ASSERT_NOW(a_cmd_count, enq, (cmd.count != 3'd0) && (cmd.count <= 3'd4), "bad request count")
    `FVX_ASSERT_NOW(a_done_quiet, phase_reg == PH_DONE, !enq, "result after outcome")
    `FVX_ASSERT_NEXT(a_end_restart, accept && body_end, (phase_reg == PH_KEY) && (kpos_reg == '0) && (used_reg == '0), "state not restored at body end")

endmodule

// ===== hw/rtl/fvx_queue.sv =====
// short request queue between the front and back parts
module fvx_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fvx_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             nonempty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && nonempty;
    assign rd_data  = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hw/rtl/fvx_back.sv =====
// back part: hands out the results of each request one at a time
module fvx_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  fvx_pkg::cmd_t    head,
    output logic             deq,
    input  logic             pop,
    output logic             empty,
    output fvx_pkg::result_t res
);
    import fvx_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    result_t    res_reg;
    logic       load;
    logic       last_of_cmd;

    // load the output register when it is free or being taken
    assign load        = head_valid && (!out_valid_reg || pop);
    assign last_of_cmd = (3'(idx_reg) == (head.count - 3'd1));
    assign deq         = load && last_of_cmd;
    assign empty       = !out_valid_reg;
    assign res         = res_reg;

    // output valid and position within the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last_of_cmd ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= head.res[idx_reg];
    end

endmodule

// ===== hw/rtl/form_field_value_extractor_unit.sv =====
// Url-encoded form value extractor: finds a configured key and decodes its value.
// Body bytes enter through push/full with body_end on the last byte of a body.
// Results leave through empty/pop: data bytes with value_valid set, then one
// closing result with last set and status found, key not found or value too long.
// Registers (key_chars, key_length, value_capacity) are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce; cfg_ready is always high.
// One body byte is accepted per cycle while full is low. Each byte is parsed in the
// cycle it is accepted and its zero to four results join a four-deep request queue,
// then pass through the single output register. Results leave at one per cycle
// while pop is high, so a byte with several results holds the back part until all leave.
// full rises only when the request queue is full; a stalled receiver therefore
// stalls the input once four pending requests have built up.
// Reset clears the queue and output register, restores the register reset values
// and returns the parser to the start of a field; no clearing pass is needed.
module form_field_value_extractor_unit #(
    parameter int KEY_MAX_CHARS   = fvx_pkg::KEY_MAX_CHARS_DEF,
    parameter int VALUE_MAX_BYTES = fvx_pkg::VALUE_MAX_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          body_byte,
    input  logic                body_end,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          value_byte,
    output logic                value_valid,
    output logic [1:0]          status,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  fvx_pkg::reg_index_t cfg_index,
    input  logic [63:0]         cfg_data
);
    import fvx_pkg::*;

    cfg_t    cfg_reg;
    logic    accept;
    logic    enq;
    cmd_t    enq_cmd;
    cmd_t    head;
    logic    head_valid;
    logic    deq;
    result_t res;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_chars      <= KEY_CHARS_RST;
            cfg_reg.key_length     <= KEY_LENGTH_RST;
            cfg_reg.value_capacity <= VALUE_CAPACITY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_CHARS:      cfg_reg.key_chars      <= cfg_data;
                REG_KEY_LENGTH:     cfg_reg.key_length     <= cfg_data[3:0];
                REG_VALUE_CAPACITY: cfg_reg.value_capacity <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // input request accepted
    assign accept = push && !full;

    fvx_front #(
        .KEY_MAX_CHARS   (KEY_MAX_CHARS),
        .VALUE_MAX_BYTES (VALUE_MAX_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .body_byte (body_byte),
        .body_end  (body_end),
        .cfg       (cfg_reg),
        .enq       (enq),
        .cmd       (enq_cmd)
    );

    fvx_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (enq),
        .wr_data  (enq_cmd),
        .full     (full),
        .rd_en    (deq),
        .rd_data  (head),
        .nonempty (head_valid)
    );

    fvx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .deq        (deq),
        .pop        (pop),
        .empty      (empty),
        .res        (res)
    );

    // result ports
    assign value_byte  = res.value_byte;
    assign value_valid = res.value_valid;
    assign status      = res.status;
    assign last        = res.last;

endmodule

// ===== bench/tb_top.sv =====
// testbench for the url-encoded form value extractor: directed and random bodies
`timescale 1ns / 100ps

module tb_top;
    import fvx_pkg::*;

    localparam int KEY_MAX      = KEY_MAX_CHARS_DEF;
    localparam int VALUE_MAX    = VALUE_MAX_BYTES_DEF;
    localparam int SETTLE_TICKS = 12;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [2:0] {
        SCAN_KEY,
        SKIP_FIELD,
        IN_VALUE,
        ESC_HIGH,
        ESC_LOW,
        SEARCH_DONE
    } parse_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  body_byte = 8'h00;
    logic        body_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  value_byte;
    logic        value_valid;
    logic [1:0]  status;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    reg_index_t  cfg_index = REG_KEY_CHARS;
    logic [63:0] cfg_data = 64'd0;

    // mirror of the registers and the parser state
    logic [63:0]  mdl_key_chars = KEY_CHARS_RST;
    logic [3:0]   mdl_key_len   = KEY_LENGTH_RST;
    logic [7:0]   mdl_capacity  = VALUE_CAPACITY_RST;
    parse_phase_t parse_phase   = SCAN_KEY;
    int           key_pos       = 0;
    int           used_count    = 0;
    logic [7:0]   held_digit    = 8'h00;

    result_t    value_expect_q[$];
    logic [7:0] body_q[$];
    result_t    oldest;
    int         err_count   = 0;
    int         cycle_count = 0;
    int         rx_hold     = 0;
    bit         tx_steady   = 1'b0;
    bit         rx_steady   = 1'b0;

    form_field_value_extractor_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .body_byte   (body_byte),
        .body_end    (body_end),
        .empty       (empty),
        .pop         (pop),
        .value_byte  (value_byte),
        .value_valid (value_valid),
        .status      (status),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // value decoder prediction
    // ------------------------------------------------------------------

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    function automatic void add_result(logic [7:0] b, logic v, status_t st, logic l);
        result_t r;
        r.value_byte  = b;
        r.value_valid = v;
        r.status      = st;
        r.last        = l;
        value_expect_q.push_back(r);
    endfunction

    function automatic void close_search(status_t st);
        add_result(8'h00, 1'b0, st, 1'b1);
        parse_phase = SEARCH_DONE;
    endfunction

    // one decoded byte if the buffer has room, else the too-long outcome
    function automatic bit store_value_byte(logic [7:0] b);
        int cap;
        cap = (mdl_capacity > VALUE_MAX) ? VALUE_MAX : int'(mdl_capacity);
        if (used_count + 1 >= cap)
        begin
            close_search(ST_TOO_LONG);
            return 1'b0;
        end
        add_result(b, 1'b1, ST_PENDING, 1'b0);
        used_count = used_count + 1;
        return 1'b1;
    endfunction

    function automatic void decode_value_char(logic [7:0] b);
        if (b == CH_AMP)
            close_search(ST_FOUND);
        else if (b == CH_PLUS)
            void'(store_value_byte(CH_SPACE));
        else if (b == CH_PCT)
            parse_phase = ESC_HIGH;
        else
            void'(store_value_byte(b));
    endfunction

    function automatic void predict_body_byte(logic [7:0] b, logic at_end);
        int         klen;
        int         hi;
        int         lo;
        logic [7:0] joined;
        klen = (mdl_key_len > KEY_MAX) ? KEY_MAX : int'(mdl_key_len);
        case (parse_phase)
            SCAN_KEY:
            begin
                if (b == CH_AMP)
                    key_pos = 0;
                else if (key_pos < klen)
                begin
                    if (b == mdl_key_chars[key_pos*8 +: 8])
                        key_pos = key_pos + 1;
                    else
                        parse_phase = SKIP_FIELD;
                end
                else if (b == CH_EQ)
                begin
                    parse_phase = IN_VALUE;
                    used_count  = 0;
                end
                else
                    parse_phase = SKIP_FIELD;
            end
            SKIP_FIELD:
            begin
                if (b == CH_AMP)
                begin
                    parse_phase = SCAN_KEY;
                    key_pos     = 0;
                end
            end
            IN_VALUE:
                decode_value_char(b);
            ESC_HIGH:
            begin
                if (hex_nibble(b) >= 0)
                begin
                    held_digit  = b;
                    parse_phase = ESC_LOW;
                end
                else if (store_value_byte(CH_PCT))
                begin
                    parse_phase = IN_VALUE;
                    decode_value_char(b);
                end
            end
            ESC_LOW:
            begin
                lo = hex_nibble(b);
                if (lo >= 0)
                begin
                    hi          = hex_nibble(held_digit);
                    joined      = 8'(hi * 16 + lo);
                    parse_phase = IN_VALUE;
                    void'(store_value_byte(joined));
                end
                else if (store_value_byte(CH_PCT) && store_value_byte(held_digit))
                begin
                    parse_phase = IN_VALUE;
                    decode_value_char(b);
                end
            end
            default: ;
        endcase

        // end of body: outcome if still open, then back to a fresh field
        if (at_end)
        begin
            case (parse_phase)
                SCAN_KEY, SKIP_FIELD:
                    close_search(ST_NOT_FOUND);
                ESC_HIGH:
                    if (store_value_byte(CH_PCT))
                        close_search(ST_FOUND);
                ESC_LOW:
                    if (store_value_byte(CH_PCT) && store_value_byte(held_digit))
                        close_search(ST_FOUND);
                IN_VALUE:
                    close_search(ST_FOUND);
                default: ;
            endcase
            parse_phase = SCAN_KEY;
            key_pos     = 0;
            used_count  = 0;
            held_digit  = 8'h00;
        end
    endfunction

    // register writes and accepted body bytes feed the mirror
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_CHARS:      mdl_key_chars = cfg_data;
                REG_KEY_LENGTH:     mdl_key_len   = cfg_data[3:0];
                REG_VALUE_CAPACITY: mdl_capacity  = cfg_data[7:0];
                default: ;
            endcase
        end
        if (rst_n && push && !full)
            predict_body_byte(body_byte, body_end);
    end

    // compare each popped result with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (value_expect_q.size() == 0)
            begin
                $error("unexpected result: value_byte %02h value_valid %0d status %0d last %0d",
                       value_byte, value_valid, status, last);
                err_count++;
            end
            else
            begin
                oldest = value_expect_q.pop_front();
                if (value_byte !== oldest.value_byte)
                begin
                    $error("value_byte: expected %02h, got %02h", oldest.value_byte, value_byte);
                    err_count++;
                end
                if (value_valid !== oldest.value_valid)
                begin
                    $error("value_valid: expected %0d, got %0d", oldest.value_valid, value_valid);
                    err_count++;
                end
                if (status !== oldest.status)
                begin
                    $error("status: expected %0d, got %0d", oldest.status, status);
                    err_count++;
                end
                if (last !== oldest.last)
                begin
                    $error("last: expected %0d, got %0d", oldest.last, last);
                    err_count++;
                end
            end
        end
    end

    // receiver: random stalls, mostly short, now and then long
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_hold != 0)
        begin
            pop <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (rx_steady || r < 65)
            pop <= 1'b1;
        else if (r < 92)
        begin
            pop <= 1'b0;
            rx_hold = $urandom_range(0, 2);
        end
        else
        begin
            pop <= 1'b0;
            rx_hold = $urandom_range(4, 19);
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] hex_char(int idx);
        if (idx < 10)
            return 8'("0" + idx);
        if (idx < 16)
            return 8'("a" + idx - 10);
        return 8'("A" + idx - 16);
    endfunction

    function automatic logic [7:0] key_char_pick();
        if ($urandom_range(0, 3) != 0)
            return 8'("a" + $urandom_range(0, 3));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [63:0] pack_key(string s);
        logic [63:0] k;
        k = 64'd0;
        for (int i = 0; i < s.len() && i < 8; i++)
            k[i*8 +: 8] = s[i];
        return k;
    endfunction

    function automatic void load_text(string s);
        for (int i = 0; i < s.len(); i++)
            body_q.push_back(s[i]);
    endfunction

    // one body byte request, held until taken, then an optional gap
    task automatic send_byte(logic [7:0] b, logic at_end);
        int g;
        @(negedge clk);
        push      <= 1'b1;
        body_byte <= b;
        body_end  <= at_end;
        @(posedge clk);
        while (full)
            @(posedge clk);
        g = tx_gap();
        if (g > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic send_body();
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < body_q.size(); i++)
            send_byte(body_q[i], i == body_q.size() - 1);
        body_q.delete();
    endtask

    task automatic send_text(string s);
        load_text(s);
        send_body();
    endtask

    // input idle, all results drained, pipeline given time to empty
    task automatic wait_quiet();
        @(negedge clk);
        push <= 1'b0;
        while (value_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry noise, the block keeps only the field
    task automatic set_config(logic [63:0] key, logic [3:0] klen, logic [7:0] cap);
        logic [63:0] data;
        wait_quiet();
        write_register(REG_KEY_CHARS, key);
        data = {$urandom, $urandom};
        data[3:0] = klen;
        write_register(REG_KEY_LENGTH, data);
        data = {$urandom, $urandom};
        data[7:0] = cap;
        write_register(REG_VALUE_CAPACITY, data);
    endtask

    function automatic void add_field_name();
        int klen;
        int r;
        int n;
        klen = (mdl_key_len > KEY_MAX) ? KEY_MAX : int'(mdl_key_len);
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            for (int i = 0; i < klen; i++)
                body_q.push_back(mdl_key_chars[i*8 +: 8]);
        end
        else if (r < 70 && klen > 0)
        begin
            // a near miss: key prefix then a stray letter
            n = $urandom_range(0, klen - 1);
            for (int i = 0; i < n; i++)
                body_q.push_back(mdl_key_chars[i*8 +: 8]);
            body_q.push_back(8'("a" + $urandom_range(0, 4)));
        end
        else
        begin
            repeat ($urandom_range(1, 3)) body_q.push_back(8'("a" + $urandom_range(0, 4)));
        end
    endfunction

    function automatic void add_value_text(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                body_q.push_back(8'($urandom_range(8'h30, 8'h7A)));
            else if (r < 65)
                body_q.push_back(CH_PLUS);
            else if (r < 80)
            begin
                body_q.push_back(CH_PCT);
                body_q.push_back(hex_char($urandom_range(0, 21)));
                body_q.push_back(hex_char($urandom_range(0, 21)));
            end
            else if (r < 88)
            begin
                // one hex digit then a non-hex one
                body_q.push_back(CH_PCT);
                body_q.push_back(hex_char($urandom_range(0, 21)));
                body_q.push_back(8'($urandom_range(8'h67, 8'h7A)));
            end
            else if (r < 93)
            begin
                body_q.push_back(CH_PCT);
                case ($urandom_range(0, 3))
                    0: body_q.push_back(CH_AMP);
                    1: body_q.push_back(CH_PLUS);
                    2: body_q.push_back(CH_PCT);
                    default: body_q.push_back(8'($urandom_range(8'h67, 8'h7A)));
                endcase
            end
            else
                body_q.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    // mostly well-formed fields, some noise and truncated bodies
    task automatic build_body(int vmax);
        int kind;
        int nf;
        int cut;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            nf = $urandom_range(1, 3);
            for (int f = 0; f < nf; f++)
            begin
                if (f > 0)
                    body_q.push_back(CH_AMP);
                add_field_name();
                if ($urandom_range(0, 99) < 85)
                    body_q.push_back(CH_EQ);
                add_value_text($urandom_range(0, vmax));
            end
            if (kind < 25 && body_q.size() > 1)
            begin
                cut = $urandom_range(1, body_q.size() - 1);
                while (body_q.size() > cut)
                    void'(body_q.pop_back());
            end
            else if (kind > 90)
            begin
                // escape left open at the end of the body
                body_q.push_back(CH_PCT);
                if (kind > 95)
                    body_q.push_back(hex_char($urandom_range(0, 21)));
            end
        end
        if (body_q.size() == 0)
            body_q.push_back(8'h7A);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers at reset: four zero key bytes, zero bytes in the body
    task automatic test_reset_config();
        body_q = '{8'h00, 8'h00, 8'h00, 8'h00, CH_EQ, CH_PLUS};
        send_body();
    endtask

    // escapes, a later field, unfinished escape at the end, capacity clamp
    task automatic test_escapes();
        set_config(pack_key("k"), 4'd1, 8'd255);
        send_text("x&k=%7e%z");
        send_text("k=%4");
    endtask

    // empty value with no room, first value byte too long, bytes after the outcome
    task automatic test_capacity_edges();
        set_config(pack_key("k"), 4'd1, 8'd0);
        send_text("k=");
        load_text("k=a");
        body_q.push_back(8'hFF);
        send_body();
    endtask

    // key holding an ampersand, key length clamp, empty key
    task automatic test_key_edges();
        set_config(pack_key("a&"), 4'd2, 8'd128);
        send_text("a&=");
        set_config(pack_key("abcdefgh"), 4'd15, 8'd128);
        send_text("abcdefgh=");
        set_config(pack_key("q"), 4'd0, 8'd1);
        set_config(pack_key("q"), 4'd0, 8'd4);
        send_text("=z");
    endtask

    task automatic test_random_bodies();
        logic [63:0] key;
        logic [3:0]  klen;
        logic [7:0]  cap;
        int          sent;
        for (int ph = 0; ph < 6; ph++)
        begin
            key = {$urandom, $urandom};
            for (int i = 0; i < 8; i++)
                key[i*8 +: 8] = key_char_pick();
            klen = 4'($urandom_range(1, 8));
            case (ph)
                0:       begin klen = 4'd0;  cap = 8'd9;   end
                1:       begin klen = 4'd15; cap = 8'd128; end
                2:       cap = 8'd2;
                3:       cap = 8'd255;
                4:       cap = 8'd1;
                default: cap = 8'($urandom_range(3, 40));
            endcase
            set_config(key, klen, cap);
            if (ph == 1)
            begin
                // value longer than the largest buffer
                for (int i = 0; i < KEY_MAX; i++)
                    body_q.push_back(key[i*8 +: 8]);
                body_q.push_back(CH_EQ);
                repeat (VALUE_MAX + 2) body_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
                send_body();
            end
            sent = 0;
            while (sent < 15)
            begin
                build_body(8);
                sent += body_q.size();
                send_body();
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_escapes();
        test_capacity_edges();
        test_key_edges();
        test_random_bodies();
        wait_quiet();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fvx_pkg.sv
hw/rtl/fvx_front.sv
hw/rtl/fvx_queue.sv
hw/rtl/fvx_back.sv
hw/rtl/form_field_value_extractor_unit.sv
bench/tb_top.sv
